>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge and ignored while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition that must never hold on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/i2cbe_pkg.sv
package i2cbe_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_RACK  = 3'd5,
    CMD_SACK  = 3'd6
  } cmd_e;

  localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;
  localparam logic [3:0] BYTE_BITS         = 4'd8;
  localparam logic [3:0] ACK_BITS          = 4'd1;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
    logic       rejected;
  } result_t;

endpackage

>>> rtl/i2cbe_if.sv
interface i2cbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] tx_byte;
  logic       ack_level;
  logic       sda_in;

  modport source (output valid, output action, output tx_byte, output ack_level,
                  output sda_in, input ready);
  modport sink (input valid, input action, input tx_byte, input ack_level,
                input sda_in, output ready);
endinterface

interface i2cbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;
  logic       rejected;

  modport source (output valid, output scl_level, output sda_level, output busy_res,
                  output done_res, output rx_byte, output ack_missing,
                  output rejected, input ready);
  modport sink (input valid, input scl_level, input sda_level, input busy_res,
                input done_res, input rx_byte, input ack_missing, input rejected,
                output ready);
endinterface

interface i2cbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] half_period_ticks;

  modport source (output valid, output half_period_ticks, input ready);
  modport sink (input valid, input half_period_ticks, output ready);
endinterface

>>> rtl/i2cbe_engine.sv
`include "assert_macros.svh"

module i2cbe_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [7:0]          half_period_i,
  input  i2cbe_pkg::item_t    item_i,
  output i2cbe_pkg::result_t  res_o
);

  i2cbe_pkg::cmd_e cmd_q, cmd_d;
  logic [2:0] ph_q, ph_d;
  logic [3:0] bi_q, bi_d;
  logic [7:0] wc_q, wc_d;
  logic [7:0] sr_q, sr_d;
  logic [7:0] rb_q, rb_d;
  logic       af_q, af_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       done;
  logic       rej;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= i2cbe_pkg::CMD_IDLE;
      ph_q  <= '0;
      bi_q  <= '0;
      wc_q  <= '0;
      sr_q  <= '0;
      rb_q  <= '0;
      af_q  <= 1'b1;
      scl_q <= 1'b1;
      sda_q <= 1'b1;
    end else if (en_i) begin
      cmd_q <= cmd_d;
      ph_q  <= ph_d;
      bi_q  <= bi_d;
      wc_q  <= wc_d;
      sr_q  <= sr_d;
      rb_q  <= rb_d;
      af_q  <= af_d;
      scl_q <= scl_d;
      sda_q <= sda_d;
    end
  end

  always_comb begin
    logic       is_cmd;
    logic       run;
    logic       hold;
    logic       fin;
    logic       is_rd;
    logic [3:0] last_bit;
    logic [7:0] hp_eff;

    cmd_d  = cmd_q;
    ph_d   = ph_q;
    bi_d   = bi_q;
    wc_d   = wc_q;
    sr_d   = sr_q;
    rb_d   = rb_q;
    af_d   = af_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    done   = 1'b0;
    rej    = 1'b0;
    run    = 1'b0;
    hold   = 1'b0;
    fin    = 1'b0;
    hp_eff = (half_period_i == '0) ? 8'd1 : half_period_i;
    is_cmd = (item_i.action >= 3'(i2cbe_pkg::CMD_START)) &&
             (item_i.action <= 3'(i2cbe_pkg::CMD_SACK));

    if (cmd_q != i2cbe_pkg::CMD_IDLE) begin
      rej = is_cmd;
      if (wc_q != '0) begin
        wc_d = wc_q - 8'd1;
      end
      run = (wc_d == '0);
    end else if (is_cmd) begin
      cmd_d = i2cbe_pkg::cmd_e'(item_i.action);
      ph_d  = '0;
      bi_d  = '0;
      case (cmd_d)
        i2cbe_pkg::CMD_WRITE: sr_d = item_i.tx_byte;
        i2cbe_pkg::CMD_SACK:  sr_d = {item_i.ack_level, 7'd0};
        default:              sr_d = '0;
      endcase
      run = 1'b1;
    end

    is_rd    = (cmd_d == i2cbe_pkg::CMD_READ) || (cmd_d == i2cbe_pkg::CMD_RACK);
    last_bit = ((cmd_d == i2cbe_pkg::CMD_WRITE) || (cmd_d == i2cbe_pkg::CMD_READ)) ?
               i2cbe_pkg::BYTE_BITS : i2cbe_pkg::ACK_BITS;

    if (run) begin
      case (cmd_d)
        i2cbe_pkg::CMD_START: begin
          if (ph_d == 3'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
            hold  = 1'b1;
          end else if (ph_d == 3'd1) begin
            sda_d = 1'b0;
            hold  = 1'b1;
          end else if (ph_d == 3'd2) begin
            scl_d = 1'b0;
            hold  = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
        i2cbe_pkg::CMD_STOP: begin
          if (ph_d == 3'd0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
            hold  = 1'b1;
          end else begin
            sda_d = 1'b1;
            fin   = 1'b1;
          end
        end
        default: begin
          if (ph_d >= 3'd3) begin
            bi_d = bi_d + 4'd1;
            if (bi_d >= last_bit) begin
              fin = 1'b1;
            end else begin
              ph_d = '0;
            end
          end
          if (!fin) begin
            if (ph_d == 3'd0) begin
              sda_d = is_rd ? 1'b1 : sr_d[3'd7 - bi_d[2:0]];
            end else if (ph_d == 3'd1) begin
              scl_d = 1'b1;
            end else begin
              if (is_rd) begin
                sr_d = {sr_d[6:0], item_i.sda_in};
              end
              scl_d = 1'b0;
            end
            hold = 1'b1;
          end
        end
      endcase
    end

    if (hold) begin
      wc_d = hp_eff;
      ph_d = ph_d + 3'd1;
    end
    if (fin) begin
      if (cmd_d == i2cbe_pkg::CMD_READ) begin
        rb_d = sr_d;
      end else if (cmd_d == i2cbe_pkg::CMD_RACK) begin
        af_d = sr_d[0];
      end
      cmd_d = i2cbe_pkg::CMD_IDLE;
      ph_d  = '0;
      bi_d  = '0;
      wc_d  = '0;
      done  = 1'b1;
    end
  end

  always_comb begin
    res_o.scl_level   = scl_d;
    res_o.sda_level   = sda_d;
    res_o.busy_res    = (cmd_d != i2cbe_pkg::CMD_IDLE);
    res_o.done_res    = done;
    res_o.rx_byte     = rb_d;
    res_o.ack_missing = af_d;
    res_o.rejected    = rej;
  end

  `ASSERT_CLK(a_done_goes_idle, clk_i, rst_ni,
              (en_i && done) |=> (cmd_q == i2cbe_pkg::CMD_IDLE))
  `ASSERT_CLK(a_idle_clean, clk_i, rst_ni,
              (cmd_q == i2cbe_pkg::CMD_IDLE) |-> (wc_q == '0 && ph_q == '0 && bi_q == '0))
  `ASSERT_CLK(a_busy_holds, clk_i, rst_ni,
              (cmd_q != i2cbe_pkg::CMD_IDLE) |-> (wc_q != '0 && bi_q < i2cbe_pkg::BYTE_BITS))
  `ASSERT_NEVER(a_reject_idle, clk_i, rst_ni,
                rej && (cmd_q == i2cbe_pkg::CMD_IDLE))

endmodule

>>> rtl/i2c_master_bit_engine.sv
// I2C master bit engine. Every transaction on the input channel is one bus timing tick and
// may carry a command (start, stop, write byte, read byte, read acknowledge, send
// acknowledge) together with the sampled SDA level; every one produces exactly one result
// transaction with the SCL and SDA levels to drive, the busy and done flags, the last
// received byte, the last acknowledge result and a flag for a command dropped while busy.
// The block takes one transaction per clock cycle, sustained, for as long as the result
// side is ready: an input register and a result register each hold one tick, so a
// transaction passes through the input register and then the result register before its
// result is offered. The half period register may be written only while no
// transaction is in flight and no command is running; a value of zero behaves as one.
`include "assert_macros.svh"

module i2c_master_bit_engine (
  input  logic  clk_i,
  input  logic  rst_ni,
  i2cbe_in_if.sink    in_i,
  i2cbe_out_if.source out_o,
  i2cbe_cfg_if.sink   cfg_i
);

  logic                s1_valid_q, s1_valid_d;
  i2cbe_pkg::item_t    s1_item_q;
  logic                out_valid_q, out_valid_d;
  i2cbe_pkg::result_t  out_q;
  i2cbe_pkg::result_t  res;
  logic [7:0]          half_period_q;
  logic                adv;
  logic                in_acc;

  assign adv         = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      half_period_q <= i2cbe_pkg::HALF_PERIOD_RESET;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        half_period_q <= cfg_i.half_period_ticks;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q.action    <= in_i.action;
      s1_item_q.tx_byte   <= in_i.tx_byte;
      s1_item_q.ack_level <= in_i.ack_level;
      s1_item_q.sda_in    <= in_i.sda_in;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  i2cbe_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .half_period_i (half_period_q),
    .item_i        (s1_item_q),
    .res_o         (res)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.scl_level   = out_q.scl_level;
  assign out_o.sda_level   = out_q.sda_level;
  assign out_o.busy_res    = out_q.busy_res;
  assign out_o.done_res    = out_q.done_res;
  assign out_o.rx_byte     = out_q.rx_byte;
  assign out_o.ack_missing = out_q.ack_missing;
  assign out_o.rejected    = out_q.rejected;

  `ASSERT_CLK(a_stall_only_when_full, clk_i, rst_ni,
              !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))
  `ASSERT_CLK(a_advance_fills_output, clk_i, rst_ni,
              adv |=> out_valid_q)
  `ASSERT_NEVER(a_input_overwrite, clk_i, rst_ni,
                in_acc && s1_valid_q && !adv)

endmodule
